### hw/rtl/dsns_pkg.sv
// Shared types, constants and SHA-256 helpers for the nonce search block.
// No dependencies.
package dsns_pkg;

   localparam int HEADER_BYTES = 80;
   localparam int DIGEST_BYTES = 32;
   localparam int HDR_WORDS    = 19;
   localparam int TGT_WORDS    = 8;

   localparam logic [2:0] OP_LOAD_HDR   = 3'd0;
   localparam logic [2:0] OP_LOAD_SHARE = 3'd1;
   localparam logic [2:0] OP_LOAD_NET   = 3'd2;
   localparam logic [2:0] OP_TRY        = 3'd3;
   localparam logic [2:0] OP_START_WIN  = 3'd4;
   localparam logic [2:0] OP_CLR_SUBMIT = 3'd5;

   localparam logic [7:0] BYTE_ONES = 8'hff;

   // Which message block a compression works on
   typedef enum logic [1:0] {
      BLK_HDR0 = 2'd0,
      BLK_HDR1 = 2'd1,
      BLK_DIG  = 2'd2
   } blk_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        capture;     // latch request fields
      logic        load_blk;    // load schedule and working vars
      blk_sel_type blk;
      logic        round;       // one SHA round
      logic        fold;        // add working vars into chaining state
      logic        compare;     // evaluate digest, update status
      logic        finish;      // form response
   } dp_cmd_type;

   typedef struct packed {
      logic       is_try;
      logic [5:0] round_idx;
   } dp_stat_type;

   function automatic logic [31:0] sha_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Byte swap: little-endian loaded word to big-endian message word
   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

### hw/rtl/double_sha256_nonce_search.sv
// Double SHA-256 nonce search. A try request hashes the loaded 76-byte
// header plus the running nonce twice on one shared round unit: a decode
// step, then three compressions of 64 rounds, one round per cycle, each
// with a load step before and a fold step after, then a compare step and
// a done step that forms the response; loads and other requests pass only
// through the decode and done steps. The next request can be accepted in
// the cycle the response appears unless that response is stalled. One request
// is in flight at a time; the response register holds a result while the
// next request waits. Depends on dsns_pkg, dsns_ctrl and dsns_dp.
module double_sha256_nonce_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_word_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_nonce_tried,
   output logic        rsp_meets_share,
   output logic        rsp_meets_block,
   output logic [8:0]  rsp_hash_zero_bits,
   output logic [8:0]  rsp_best_lead_zeros,
   output logic [31:0] rsp_shares_total,
   output logic [31:0] rsp_hashes_in_window,
   output logic        rsp_share_in_window,
   output logic        rsp_block_in_window,
   output logic        rsp_submit_pending,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_network_target_enabled
);
   import dsns_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        net_en_ff;

   // Config register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) net_en_ff <= 1'b0;
      else if (csr_valid && csr_ready) net_en_ff <= csr_network_target_enabled;
   end

   dsns_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd
   );

   dsns_dp u_dp (
      .clock, .reset, .cmd, .stat, .net_en(net_en_ff),
      .req_opcode, .req_word_index, .req_word_value,
      .rsp_nonce_tried, .rsp_meets_share, .rsp_meets_block,
      .rsp_hash_zero_bits, .rsp_best_lead_zeros, .rsp_shares_total,
      .rsp_hashes_in_window, .rsp_share_in_window, .rsp_block_in_window,
      .rsp_submit_pending
   );

`ifndef NO_ASSERTIONS
   // No new request while a try is being hashed
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (cmd.round || cmd.load_blk || cmd.fold) |-> req_stall)
      else $error("request accepted during hashing");
   // A held response stays held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_nonce_tried)))
      else $error("stalled response changed");
   // Meeting block implies meeting share
   a_block_share: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_meets_block |-> rsp_meets_share)
      else $error("block without share");
`endif
endmodule

### hw/rtl/dsns_ctrl.sv
// Sequencer for the nonce search: decodes each request and, for a try, steps three compressions of 64 rounds.
// Depends on dsns_pkg.
module dsns_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  dsns_pkg::dp_stat_type stat,
   output dsns_pkg::dp_cmd_type  cmd
);
   import dsns_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_FOLD  = 7'b0001000,
      ST_CMP   = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_DEC   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   blk_sel_type blk_ff, blk_in;
   logic        rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.blk      = blk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.capture = 1'b1;
               state_in    = ST_DEC;
            end
         end
         ST_DEC: begin
            if (stat.is_try) begin
               blk_in   = BLK_HDR0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LOAD: begin
            cmd.load_blk = 1'b1;
            state_in     = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (stat.round_idx == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            unique case (blk_ff)
               BLK_HDR0: begin blk_in = BLK_HDR1; state_in = ST_LOAD; end
               BLK_HDR1: begin blk_in = BLK_DIG;  state_in = ST_LOAD; end
               default:  state_in = ST_CMP;
            endcase
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blk_ff       <= BLK_HDR0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blk_ff       <= blk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### hw/rtl/dsns_dp.sv
// Datapath: word stores, SHA-256 round unit with rolling schedule, compare
// and counters. Depends on dsns_pkg.
module dsns_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  dsns_pkg::dp_cmd_type  cmd,
   output dsns_pkg::dp_stat_type stat,
   input  logic                 net_en,
   input  logic [2:0]           req_opcode,
   input  logic [4:0]           req_word_index,
   input  logic [31:0]          req_word_value,
   output logic [31:0]          rsp_nonce_tried,
   output logic                 rsp_meets_share,
   output logic                 rsp_meets_block,
   output logic [8:0]           rsp_hash_zero_bits,
   output logic [8:0]           rsp_best_lead_zeros,
   output logic [31:0]          rsp_shares_total,
   output logic [31:0]          rsp_hashes_in_window,
   output logic                 rsp_share_in_window,
   output logic                 rsp_block_in_window,
   output logic                 rsp_submit_pending
);
   import dsns_pkg::*;

   logic [31:0] hdr_ff [HDR_WORDS];
   logic [31:0] stgt_ff [TGT_WORDS];
   logic [31:0] ntgt_ff [TGT_WORDS];
   logic [2:0]  op_ff;

   logic [31:0]  nonce_ff;
   logic [255:0] best_ff;
   logic [8:0]   best_zc_ff;
   logic [31:0]  shares_ff, win_cnt_ff;
   logic [1:0]   win_flags_ff;
   logic         submit_ff;

   logic [255:0] chain_ff, mid_ff;   // chaining state; first-hash result
   logic [31:0]  v_ff [8];
   logic [31:0]  w_ff [16];
   logic [5:0]   rnd_ff;
   logic         ms_ff, mb_ff;
   logic [8:0]   zb_ff;

   // Response registers
   logic [31:0] o_nonce_ff, o_shares_ff, o_win_ff;
   logic        o_ms_ff, o_mb_ff, o_sw_ff, o_bw_ff, o_sub_ff;
   logic [8:0]  o_zb_ff, o_bz_ff;

   assign stat.is_try   = (op_ff == OP_TRY);
   assign stat.round_idx = rnd_ff;

   // Message block selection
   logic [31:0] msg [16];
   always_comb begin
      for (int i = 0; i < 16; i++) msg[i] = '0;
      case (cmd.blk)
         BLK_HDR0: for (int i = 0; i < 16; i++) msg[i] = bswap(hdr_ff[i]);
         BLK_HDR1: begin
            msg[0] = bswap(hdr_ff[16]);
            msg[1] = bswap(hdr_ff[17]);
            msg[2] = bswap(hdr_ff[18]);
            msg[3] = bswap(nonce_ff);
            msg[4] = 32'h80000000;
            msg[15] = 32'(8 * HEADER_BYTES);
         end
         default: begin
            for (int i = 0; i < 8; i++) msg[i] = mid_ff[255-32*i -: 32];
            msg[8]  = 32'h80000000;
            msg[15] = 32'(8 * DIGEST_BYTES);
         end
      endcase
   end

   // Round logic
   logic [31:0] t1, t2, s0, s1, w_new;
   always_comb begin
      t1 = v_ff[7] + (rotr(v_ff[4],6) ^ rotr(v_ff[4],11) ^ rotr(v_ff[4],25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + sha_k(rnd_ff) + w_ff[0];
      t2 = (rotr(v_ff[0],2) ^ rotr(v_ff[0],13) ^ rotr(v_ff[0],22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = rotr(w_ff[1],7) ^ rotr(w_ff[1],18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14],17) ^ rotr(w_ff[14],19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
   end

   // Fold result
   logic [255:0] folded;
   always_comb begin
      for (int i = 0; i < 8; i++) folded[255-32*i -: 32] = chain_ff[255-32*i -: 32] + v_ff[i];
   end

   // Digest evaluation: raw bytes d[i] = chain_ff[255-8i -: 8]
   logic        le_share, le_net, less_best;
   logic [8:0]  zcount;
   always_comb begin
      logic done_s, done_n, done_b, hit;
      logic [7:0] d, ts, tn, b;
      le_share = 1'b1; le_net = 1'b1; less_best = 1'b0;
      done_s = 1'b0; done_n = 1'b0; done_b = 1'b0;
      for (int i = DIGEST_BYTES-1; i >= 0; i--) begin
         d  = chain_ff[255-8*i -: 8];
         ts = stgt_ff[i/4][8*(i%4) +: 8];
         tn = ntgt_ff[i/4][8*(i%4) +: 8];
         if (!done_s && d != ts) begin le_share = (d < ts); done_s = 1'b1; end
         if (!done_n && d != tn) begin le_net = (d < tn); done_n = 1'b1; end
      end
      for (int i = 0; i < DIGEST_BYTES; i++) begin
         d = chain_ff[255-8*i -: 8];
         b = best_ff[255-8*i -: 8];
         if (!done_b && d != b) begin less_best = (d < b); done_b = 1'b1; end
      end
      zcount = 9'd256;
      hit = 1'b0;
      for (int j = 0; j < 256; j++) begin
         if (!hit && chain_ff[255-j]) begin zcount = 9'(j); hit = 1'b1; end
      end
   end

   // Stores and request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         if (req_opcode == OP_LOAD_HDR && req_word_index < 5'(HDR_WORDS))
            hdr_ff[req_word_index] <= req_word_value;
         if (req_opcode == OP_LOAD_SHARE && req_word_index < 5'(TGT_WORDS))
            stgt_ff[req_word_index[2:0]] <= req_word_value;
         if (req_opcode == OP_LOAD_NET && req_word_index < 5'(TGT_WORDS))
            ntgt_ff[req_word_index[2:0]] <= req_word_value;
      end
   end

   // Hash engine
   always_ff @(posedge clock) begin
      if (cmd.load_blk) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= msg[i];
         if (cmd.blk == BLK_HDR1)
            for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[255-32*i -: 32];
         else begin
            for (int i = 0; i < 8; i++) v_ff[i] <= SHA_IV[255-32*i -: 32];
            chain_ff <= SHA_IV;
         end
         rnd_ff <= '0;
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         rnd_ff  <= rnd_ff + 6'd1;
      end else if (cmd.fold) begin
         chain_ff <= folded;
         if (cmd.blk == BLK_HDR1) mid_ff <= folded;
      end
   end

   // Status state
   always_ff @(posedge clock) begin
      if (reset) begin
         nonce_ff     <= '0;
         best_ff      <= {DIGEST_BYTES{BYTE_ONES}};
         best_zc_ff   <= '0;
         shares_ff    <= '0;
         win_cnt_ff   <= '0;
         win_flags_ff <= '0;
         submit_ff    <= 1'b0;
         ms_ff        <= 1'b0;
         mb_ff        <= 1'b0;
         zb_ff        <= '0;
      end else begin
         if (cmd.capture) begin
            ms_ff <= 1'b0; mb_ff <= 1'b0; zb_ff <= '0;
            if (req_opcode == OP_START_WIN) begin
               win_cnt_ff   <= '0;
               win_flags_ff <= '0;
            end
            if (req_opcode == OP_CLR_SUBMIT) submit_ff <= 1'b0;
         end
         if (cmd.compare) begin
            zb_ff <= zcount;
            if (less_best) begin
               best_ff    <= chain_ff;
               best_zc_ff <= zcount;
            end
            if (le_share) begin
               ms_ff           <= 1'b1;
               win_flags_ff[0] <= 1'b1;
               submit_ff       <= 1'b1;
               shares_ff       <= shares_ff + 32'd1;
               if (net_en && le_net) begin
                  mb_ff           <= 1'b1;
                  win_flags_ff[1] <= 1'b1;
               end
            end
            nonce_ff   <= nonce_ff + 32'd1;
            win_cnt_ff <= win_cnt_ff + 32'd1;
         end
      end
   end

   // Response capture; nonce_tried is the pre-increment value
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         o_nonce_ff  <= stat.is_try ? nonce_ff - 32'd1 : nonce_ff;
         o_ms_ff     <= ms_ff;
         o_mb_ff     <= mb_ff;
         o_zb_ff     <= zb_ff;
         o_bz_ff     <= best_zc_ff;
         o_shares_ff <= shares_ff;
         o_win_ff    <= win_cnt_ff;
         o_sw_ff     <= win_flags_ff[0];
         o_bw_ff     <= win_flags_ff[1];
         o_sub_ff    <= submit_ff;
      end
   end

   assign rsp_nonce_tried      = o_nonce_ff;
   assign rsp_meets_share      = o_ms_ff;
   assign rsp_meets_block      = o_mb_ff;
   assign rsp_hash_zero_bits   = o_zb_ff;
   assign rsp_best_lead_zeros  = o_bz_ff;
   assign rsp_shares_total     = o_shares_ff;
   assign rsp_hashes_in_window = o_win_ff;
   assign rsp_share_in_window  = o_sw_ff;
   assign rsp_block_in_window  = o_bw_ff;
   assign rsp_submit_pending   = o_sub_ff;
endmodule
